FILE: rtl/core/dhq_pkg.sv
// ----------------------------------------------------------------------------
// dhq_pkg
// Types and constants shared by the d-ary min-heap queue core.
// ----------------------------------------------------------------------------
package dhq_pkg;

  localparam int Capacity = 1024;
  localparam int AddrW    = $clog2(Capacity);
  localparam int CountW   = $clog2(Capacity + 1);

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_DELMIN  = 2'd1;
  localparam logic [1:0] OP_DELKEY  = 2'd2;
  localparam logic [1:0] OP_NOP     = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] key_value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] min_value;
    logic               key_found;
    logic [1:0]         status;
    logic [15:0]        step_count;
  } out_word_t;

  // Signed compare of two keys.
  function automatic logic key_less(logic [31:0] a, logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

endpackage

FILE: rtl/core/dhq_ram.sv
// ----------------------------------------------------------------------------
// dhq_ram
// Single-port synchronous key store with a registered read.
// ----------------------------------------------------------------------------
module dhq_ram #(
  parameter int Depth = 1024,
  parameter int Width = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/core/dary_min_heap_queue_core.sv
// ----------------------------------------------------------------------------
// dary_min_heap_queue_core
// Min-heap priority queue of signed keys with arity set by a register.
// ----------------------------------------------------------------------------
// A command word (in_word) is taken when start is high and busy is low.
// Exactly one result word appears on out_word for one cycle with out_valid
// high; the receiver cannot stall it. cfg_we writes the arity register
// (values below two act as two, above eight as eight); write it only idle.
// All keys live in one single-port RAM with a registered read, so each
// heap access is a read state and a wait state.
// Insert climbs from the new slot, reading, waiting on and comparing one
// parent per level. Delete-min reads the root and the last key, then per
// level reads each child in turn and writes the best child up.
// Delete-key reads and checks every held key; each survivor is re-inserted
// at slot kept and climbs like an insert.
// A full heap on insert or an empty one on delete-min answers with no state
// change.
// busy stays high through the strobe cycle, so the next word is taken in the
// cycle after the strobe at the earliest.
// Reset clears the count and the arity to two; the RAM is not cleared, as
// only slots below the count are ever read.
// ----------------------------------------------------------------------------
module dary_min_heap_queue_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  dhq_pkg::in_word_t   in_word,
  output logic                out_valid,
  output dhq_pkg::out_word_t  out_word,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_wdata
);

  localparam int AW = dhq_pkg::AddrW;
  localparam int CW = dhq_pkg::CountW;

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_UPRD   = 15'b000000000000010,  // read parent
    S_UPWT   = 15'b000000000000100,
    S_UPCMP  = 15'b000000000001000,  // compare, write current slot
    S_DMRD0  = 15'b000000000010000,  // read root
    S_DMRDL  = 15'b000000000100000,  // read last
    S_DMWT   = 15'b000000001000000,
    S_DMCH   = 15'b000000010000000,  // read one child
    S_DMCWT  = 15'b000000100000000,
    S_DMSWP  = 15'b000001000000000,  // write best child into parent slot
    S_DONE   = 15'b000010000000000,
    S_DKRD   = 15'b000100000000000,  // read entry i
    S_DKWT   = 15'b001000000000000,
    S_DKCHK  = 15'b010000000000000,
    S_DMWR   = 15'b100000000000000   // write moving key at final slot
  } state_t;

  state_t state_r, state_nxt;

  logic [3:0]  arity_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [3:0]  m;

  logic [1:0]  op_r, op_nxt;
  logic [31:0] key_r, key_nxt;       // key being moved
  logic [31:0] dkey_r, dkey_nxt;     // key to delete
  logic [AW-1:0] cur_r, cur_nxt;
  logic [AW-1:0] best_r, best_nxt;
  logic [31:0] bestv_r, bestv_nxt;
  logic [3:0]  j_r, j_nxt;
  logic [CW-1:0] i_r, i_nxt;         // delete-key scan index
  logic [CW-1:0] kept_r, kept_nxt;
  logic [15:0] steps_r, steps_nxt;
  logic        found_r, found_nxt;
  dhq_pkg::out_word_t res_r, res_nxt;
  logic        ov_r, ov_nxt;

  logic          we;
  logic [AW-1:0] addr;
  logic [31:0]   wdata, rdata;

  // Tree index arithmetic; products stay inside 11 + 4 bits.
  logic [AW-1:0]  par;
  logic [CW+3:0]  first_w;
  logic [CW+3:0]  child_w;
  logic [15:0]    steps_inc;

  dhq_ram #(.Depth(dhq_pkg::Capacity), .Width(32)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  always_comb begin
    if (arity_r < 4'd2) m = 4'd2;
    else if (arity_r > 4'd8) m = 4'd8;
    else m = arity_r;
  end

  // Parent by a multiply with ceil(2^20 / m) and a shift by 20. The rounding
  // error times the largest index stays below 2^20, so the quotient is exact.
  always_comb begin
    logic [AW-1:0] c1;
    logic [19:0]   recip;
    logic [29:0]   prod;
    c1 = cur_r - AW'(1);
    case (m)
      4'd2:    recip = 20'd524288;
      4'd3:    recip = 20'd349526;
      4'd4:    recip = 20'd262144;
      4'd5:    recip = 20'd209716;
      4'd6:    recip = 20'd174763;
      4'd7:    recip = 20'd149797;
      default: recip = 20'd131072;
    endcase
    prod = 30'(c1) * 30'(recip);
    par  = prod[29:20];
  end

  assign first_w   = (CW+4)'(cur_r) * (CW+4)'(m) + (CW+4)'(1);
  assign child_w   = first_w + (CW+4)'(j_r);
  assign steps_inc = (steps_r == 16'hFFFF) ? steps_r : steps_r + 16'd1;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    op_nxt = op_r; key_nxt = key_r; dkey_nxt = dkey_r;
    cur_nxt = cur_r; best_nxt = best_r; bestv_nxt = bestv_r;
    j_nxt = j_r; i_nxt = i_r; kept_nxt = kept_r;
    steps_nxt = steps_r; found_nxt = found_r;
    res_nxt = res_r; ov_nxt = 1'b0;
    we = 1'b0; addr = cur_r; wdata = key_r;

    unique case (state_r)
      S_IDLE: begin
        // The strobe cycle still counts as busy.
        if (start && !ov_r) begin
          op_nxt = in_word.opcode;
          key_nxt = in_word.key_value;
          dkey_nxt = in_word.key_value;
          steps_nxt = '0;
          found_nxt = 1'b0;
          res_nxt = '0;
          case (in_word.opcode)
            dhq_pkg::OP_INSERT: begin
              if (count_r >= CW'(dhq_pkg::Capacity)) begin
                res_nxt.status = dhq_pkg::ST_FULL;
                state_nxt = S_DONE;
              end else begin
                cur_nxt = count_r[AW-1:0];
                steps_nxt = 16'd1;
                count_nxt = count_r + CW'(1);
                state_nxt = S_UPRD;
              end
            end
            dhq_pkg::OP_DELMIN: begin
              if (count_r == '0) begin
                res_nxt.status = dhq_pkg::ST_EMPTY;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_DMRD0;
              end
            end
            dhq_pkg::OP_DELKEY: begin
              i_nxt = '0;
              kept_nxt = '0;
              state_nxt = S_DKRD;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      // Sift-up: the moving key is written only at its final slot; parents
      // that it passes are shifted down one at a time.
      S_UPRD: begin
        if (cur_r == '0) begin
          we = 1'b1; addr = cur_r; wdata = key_r;
          state_nxt = (op_r == dhq_pkg::OP_DELKEY) ? S_DKRD : S_DONE;
        end else begin
          addr = par;
          best_nxt = par;
          state_nxt = S_UPWT;
        end
      end
      S_UPWT: begin
        addr = best_r;
        state_nxt = S_UPCMP;
      end
      S_UPCMP: begin
        if (dhq_pkg::key_less(key_r, rdata)) begin
          we = 1'b1; addr = cur_r; wdata = rdata;
          cur_nxt = best_r;
          steps_nxt = steps_inc;
          state_nxt = S_UPRD;
        end else begin
          we = 1'b1; addr = cur_r; wdata = key_r;
          state_nxt = (op_r == dhq_pkg::OP_DELKEY) ? S_DKRD : S_DONE;
        end
      end

      S_DMRD0: begin
        addr = '0;
        count_nxt = count_r - CW'(1);
        state_nxt = S_DMRDL;
      end
      S_DMRDL: begin
        res_nxt.min_value = rdata;
        addr = count_r[AW-1:0];
        cur_nxt = '0;
        state_nxt = S_DMWT;
      end
      S_DMWT: begin
        key_nxt = rdata;
        bestv_nxt = rdata;
        best_nxt = '0;
        j_nxt = '0;
        state_nxt = S_DMCH;
      end
      S_DMCH: begin
        if (j_r == m || child_w >= (CW+4)'(count_r)) begin
          if (best_r == cur_r) begin
            state_nxt = S_DMWR;
          end else begin
            state_nxt = S_DMSWP;
          end
        end else begin
          addr = child_w[AW-1:0];
          state_nxt = S_DMCWT;
        end
      end
      S_DMCWT: begin
        if (dhq_pkg::key_less(rdata, bestv_r)) begin
          bestv_nxt = rdata;
          best_nxt = child_w[AW-1:0];
        end
        j_nxt = j_r + 4'd1;
        state_nxt = S_DMCH;
      end
      S_DMSWP: begin
        we = 1'b1; addr = cur_r; wdata = bestv_r;
        steps_nxt = steps_inc;
        cur_nxt = best_r;
        bestv_nxt = key_r;
        j_nxt = '0;
        state_nxt = S_DMCH;
      end
      S_DMWR: begin
        we = 1'b1; addr = cur_r; wdata = key_r;
        state_nxt = S_DONE;
      end

      // Delete-key: survivors re-enter at slot kept; kept never passes i,
      // so entries still to be scanned are untouched.
      S_DKRD: begin
        if (i_r >= count_r) begin
          count_nxt = kept_r;
          res_nxt.key_found = found_r;
          state_nxt = S_DONE;
        end else begin
          addr = i_r[AW-1:0];
          state_nxt = S_DKWT;
        end
      end
      S_DKWT: begin
        addr = i_r[AW-1:0];
        state_nxt = S_DKCHK;
      end
      S_DKCHK: begin
        i_nxt = i_r + CW'(1);
        if (rdata == dkey_r) begin
          found_nxt = 1'b1;
          state_nxt = S_DKRD;
        end else begin
          key_nxt = rdata;
          cur_nxt = kept_r[AW-1:0];
          kept_nxt = kept_r + CW'(1);
          steps_nxt = steps_inc;
          state_nxt = S_UPRD;
        end
      end

      S_DONE: begin
        res_nxt.step_count = steps_r;
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      arity_r <= 4'd2;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) arity_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt; key_r <= key_nxt; dkey_r <= dkey_nxt;
    cur_r <= cur_nxt; best_r <= best_nxt; bestv_r <= bestv_nxt;
    j_r <= j_nxt; i_r <= i_nxt; kept_r <= kept_nxt;
    steps_r <= steps_nxt; found_r <= found_nxt; res_r <= res_nxt;
  end

  assign busy      = (state_r != S_IDLE) || ov_r;
  assign out_valid = ov_r;
  assign out_word  = res_r;

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(dhq_pkg::Capacity))
    else $error("entry count above capacity");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held two cycles");
  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |=> out_valid)
    else $error("done without result");
`endif

endmodule
